### rtl/mafd_pkg.sv
package mafd_pkg;

	localparam int unsigned FRAME_W = 12;
	localparam int unsigned BASE_W = 12;
	localparam int unsigned SCALED_W = 20;

	localparam logic [10:0] SYNC_WORD = 11'h7FF;

	// floor(x * RECIP_441 >> RECIP_SHIFT) == floor(x / 441) for every x below 2**20
	localparam int unsigned RECIP_SHIFT = 29;
	localparam logic [20:0] RECIP_441 = 21'd1217395;

	localparam logic [1:0] VER_MPEG1 = 2'd0;
	localparam logic [1:0] VER_RSVD = 2'd3;
	localparam logic [1:0] LAYER_1 = 2'd1;
	localparam logic [1:0] LAYER_2 = 2'd2;
	localparam logic [1:0] LAYER_3 = 2'd3;
	localparam logic [1:0] MODE_MONO = 2'd3;

	// reduced divisor per sample-rate index: 44100 -> 441/240, 48000 -> 2, 32000 -> 4/3
	typedef enum logic [1:0] {
		DIV_BY_441 = 2'd0,
		DIV_BY_2   = 2'd1,
		DIV_BY_4_3 = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic        ok;
		logic [1:0]  mpeg_version;
		logic [1:0]  layer;
		logic        has_crc;
		logic [8:0]  bitrate_kbps;
		logic [15:0] sample_rate_hz;
		logic [2:0]  padding_bytes;
		logic [1:0]  channel_count;
		logic [1:0]  channel_mode;
		logic [1:0]  mode_extension;
		logic [1:0]  emphasis;
	} hdr_info_t;

	// raw version code to decoded version
	localparam logic [1:0] VER_MAP [0:3] = '{2'd2, 2'd3, 2'd1, 2'd0};

	// rows indexed by layer number, row 0 is the reserved layer
	localparam logic [8:0] BR_V1 [0:3][0:15] = '{
		'{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
		  9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		  9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
		'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		  9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
		'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		  9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
	};

	localparam logic [8:0] BR_V2 [0:3][0:15] = '{
		'{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
		  9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		  9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
		'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
		'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
	};

	// indexed by decoded version, then sample-rate index
	localparam logic [15:0] FREQ_TAB [0:3][0:3] = '{
		'{16'd44100, 16'd48000, 16'd32000, 16'd0},
		'{16'd22050, 16'd24000, 16'd16000, 16'd0},
		'{16'd11025, 16'd12000, 16'd8000, 16'd0},
		'{16'd0, 16'd0, 16'd0, 16'd0}
	};

endpackage

### rtl/mpeg_audio_frame_header_decoder_unit.sv
// Four register stages: decode and table lookup, numerator scaling, reciprocal
// multiply, frame-length add into the output register.
// Throughput: one header per cycle when res_ready does not stall the output;
// the 21x20 reciprocal multiply sets the stage depth.
// Each stage holds its beat until the next one frees, so output stalls lose nothing.
// Reset (arst_n low, asynchronous) empties the pipe; payload registers keep no reset.
module mpeg_audio_frame_header_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hdr_valid,
	output logic        hdr_ready,
	input  logic [31:0] header_word,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        valid_res,
	output logic [1:0]  mpeg_version,
	output logic [1:0]  layer,
	output logic        has_crc,
	output logic [8:0]  bitrate_kbps,
	output logic [15:0] sample_rate_hz,
	output logic [2:0]  padding_bytes,
	output logic [11:0] frame_bytes,
	output logic [1:0]  channel_count,
	output logic [1:0]  channel_mode,
	output logic [1:0]  mode_extension,
	output logic [1:0]  emphasis
);
	import mafd_pkg::*;

	// stage 1 to stage 2 beat
	logic      v_s1;
	logic      rdy_s1;
	hdr_info_t info_s1;
	logic [11:0] base_s1;
	div_sel_t  sel_s1;

	// stage 3 to output beat
	logic      v_s3;
	hdr_info_t info_s3;
	logic [11:0] quo_s3;
	logic      rdy_s4;

	mafd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.hdr_valid   (hdr_valid),
		.hdr_ready   (hdr_ready),
		.header_word (header_word),
		.v_s1        (v_s1),
		.dn_ready    (rdy_s1),
		.info_s1     (info_s1),
		.base_s1     (base_s1),
		.sel_s1      (sel_s1)
	);

	mafd_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_s1),
		.up_ready (rdy_s1),
		.up_info  (info_s1),
		.up_base  (base_s1),
		.up_sel   (sel_s1),
		.v_s3     (v_s3),
		.dn_ready (rdy_s4),
		.info_s3  (info_s3),
		.quo_s3   (quo_s3)
	);

	// output register frees whenever the consumer takes the beat
	assign rdy_s4 = ~res_valid | res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (rdy_s4) begin
			res_valid <= v_s3;
		end
	end

	// quotient and padding are both zero for a bad header, so the sum is too
	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			valid_res <= info_s3.ok;
			mpeg_version <= info_s3.mpeg_version;
			layer <= info_s3.layer;
			has_crc <= info_s3.has_crc;
			bitrate_kbps <= info_s3.bitrate_kbps;
			sample_rate_hz <= info_s3.sample_rate_hz;
			padding_bytes <= info_s3.padding_bytes;
			frame_bytes <= quo_s3 + {9'b0, info_s3.padding_bytes};
			channel_count <= info_s3.channel_count;
			channel_mode <= info_s3.channel_mode;
			mode_extension <= info_s3.mode_extension;
			emphasis <= info_s3.emphasis;
		end
	end

endmodule

### rtl/mafd_decode.sv
module mafd_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hdr_valid,
	output logic                 hdr_ready,
	input  logic [31:0]          header_word,
	output logic                 v_s1,
	input  logic                 dn_ready,
	output mafd_pkg::hdr_info_t  info_s1,
	output logic [11:0]          base_s1,
	output mafd_pkg::div_sel_t   sel_s1
);
	import mafd_pkg::*;

	logic [1:0]  ver;
	logic [1:0]  lcode;
	logic [1:0]  layer;
	logic [3:0]  bidx;
	logic [1:0]  fidx;
	logic [8:0]  kbps;
	logic [15:0] freq;
	logic        ok;
	logic [10:0] kbps_x3;
	logic [11:0] kbps_m;
	logic [11:0] base;
	div_sel_t    sel;
	hdr_info_t   info;

	always_comb begin
		ver = VER_MAP[header_word[20:19]];
		lcode = header_word[18:17];
		layer = (lcode == 2'd0) ? 2'd0 : 2'(3'd4 - {1'b0, lcode});
		bidx = header_word[15:12];
		fidx = header_word[11:10];
		kbps = (ver == VER_MPEG1 || ver == VER_RSVD) ? BR_V1[layer][bidx] : BR_V2[layer][bidx];
		freq = FREQ_TAB[ver][fidx];
		ok = (header_word[31:21] == SYNC_WORD) && (freq != 16'd0) && (kbps != 9'd0);

		// frame factor over 24000: Layer I 2, Layer II 6, Layer III 6 or 3
		kbps_x3 = {1'b0, kbps, 1'b0} + {2'b0, kbps};
		if (layer == LAYER_1) begin
			kbps_m = {2'b0, kbps, 1'b0};
		end else if (layer == LAYER_2 || (layer == LAYER_3 && ver == VER_MPEG1)) begin
			kbps_m = {kbps_x3, 1'b0};
		end else begin
			kbps_m = {1'b0, kbps_x3};
		end
		// sample rate halves per version step, so scale the numerator instead
		base = ok ? 12'(kbps_m << ver) : '0;

		unique case (fidx)
			2'd0:    sel = DIV_BY_441;
			2'd1:    sel = DIV_BY_2;
			default: sel = DIV_BY_4_3;
		endcase

		info.ok = ok;
		info.mpeg_version = ver;
		info.layer = layer;
		info.has_crc = ~header_word[16];
		info.bitrate_kbps = ok ? kbps : '0;
		info.sample_rate_hz = ok ? freq : '0;
		info.padding_bytes = (ok && header_word[9]) ? ((layer == LAYER_1) ? 3'd4 : 3'd1) : 3'd0;
		info.channel_count = (header_word[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
		info.channel_mode = header_word[7:6];
		info.mode_extension = header_word[5:4];
		info.emphasis = header_word[1:0];
	end

	assign hdr_ready = ~v_s1 | dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (hdr_ready) begin
			v_s1 <= hdr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_valid && hdr_ready) begin
			info_s1 <= info;
			base_s1 <= base;
			sel_s1 <= sel;
		end
	end

endmodule

### rtl/mafd_scale.sv
module mafd_scale (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  mafd_pkg::hdr_info_t  up_info,
	input  logic [11:0]          up_base,
	input  mafd_pkg::div_sel_t   up_sel,
	output logic                 v_s3,
	input  logic                 dn_ready,
	output mafd_pkg::hdr_info_t  info_s3,
	output logic [11:0]          quo_s3
);
	import mafd_pkg::*;

	logic                v_s2;
	hdr_info_t           info_s2;
	logic [SCALED_W-1:0] x_s2;
	div_sel_t            sel_s2;
	logic                rdy_s2;
	logic                rdy_s3;
	logic [SCALED_W-1:0] x;
	logic [40:0]         prod;
	logic [FRAME_W-1:0]  quo;

	assign rdy_s3 = ~v_s3 | dn_ready;
	assign rdy_s2 = ~v_s2 | rdy_s3;
	assign up_ready = rdy_s2;

	// stage 2: numerator of the reduced fraction
	always_comb begin
		case (up_sel)
			DIV_BY_441: x = {up_base, 8'b0} - {4'b0, up_base, 4'b0};
			DIV_BY_4_3: x = {8'b0, up_base} + {7'b0, up_base, 1'b0};
			default:    x = {8'b0, up_base};
		endcase
	end

	// stage 3: reciprocal multiply for 441, plain shifts otherwise
	always_comb begin
		prod = {21'b0, x_s2} * {20'b0, RECIP_441};
		case (sel_s2)
			DIV_BY_441: quo = prod[RECIP_SHIFT +: FRAME_W];
			DIV_BY_4_3: quo = FRAME_W'(x_s2 >> 2);
			default:    quo = FRAME_W'(x_s2 >> 1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= up_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && rdy_s2) begin
			info_s2 <= up_info;
			x_s2 <= x;
			sel_s2 <= up_sel;
		end
		if (v_s2 && rdy_s3) begin
			info_s3 <= info_s2;
			quo_s3 <= quo;
		end
	end

endmodule

### rtl/mafd_checker.sv
module mafd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        valid_res,
	input logic [8:0]  bitrate_kbps,
	input logic [15:0] sample_rate_hz,
	input logic [2:0]  padding_bytes,
	input logic [11:0] frame_bytes,
	input logic [1:0]  channel_count,
	input logic [1:0]  channel_mode
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(frame_bytes) && $stable(valid_res))
		else $error("result beat changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !valid_res |-> frame_bytes == 12'd0 && bitrate_kbps == 9'd0
			&& sample_rate_hz == 16'd0 && padding_bytes == 3'd0)
		else $error("invalid header carries nonzero computed fields");

	a_good_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && valid_res |-> frame_bytes > {9'b0, padding_bytes}
			&& sample_rate_hz != 16'd0 && bitrate_kbps != 9'd0)
		else $error("valid header with empty frame or rate");

	a_chan_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (channel_mode == 2'd3) == (channel_count == 2'd1)
			&& (channel_count == 2'd1 || channel_count == 2'd2))
		else $error("channel count disagrees with channel mode");

endmodule

bind mpeg_audio_frame_header_decoder_unit mafd_checker u_mafd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res_valid),
	.res_ready      (res_ready),
	.valid_res      (valid_res),
	.bitrate_kbps   (bitrate_kbps),
	.sample_rate_hz (sample_rate_hz),
	.padding_bytes  (padding_bytes),
	.frame_bytes    (frame_bytes),
	.channel_count  (channel_count),
	.channel_mode   (channel_mode)
);
